FILE: design/oft_pkg.sv
// Shared types, codes and sizes for the ordered free-block table.
`timescale 1ns / 1ps
package oft_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    localparam logic [2:0] OP_ADD_FRONT = 3'd0;
    localparam logic [2:0] OP_ADD_BACK  = 3'd1;
    localparam logic [2:0] OP_ORD_INS   = 3'd2;
    localparam logic [2:0] OP_COALESCE  = 3'd3;
    localparam logic [2:0] OP_REM_FRONT = 3'd4;
    localparam logic [2:0] OP_REM_BACK  = 3'd5;
    localparam logic [2:0] OP_FIND_REM  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] block_address;
        logic [31:0] block_size;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_address;
        logic [31:0]        out_size;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } mem_req_t;

endpackage

FILE: design/oft_mem.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module oft_mem (
    input  logic            clk,
    input  oft_pkg::mem_req_t req,
    output oft_pkg::entry_t rd_data
);
    import oft_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_idx];
        end
    end

endmodule

FILE: design/ordered_free_block_table.sv
// Top level: sequencer that walks and shifts the entry store per command.
//
//  channel | signals            | handshake
//  --------+--------------------+-------------------------------------------
//  command | start, busy, cmd   | word taken on edge with start & !busy
//  result  | done, result       | word valid one cycle with done, no stall
//
// An operation's length from the accepting edge to the result strobe is set by
// the one-read port of the entry store: scans, shifts and the coalesce pass
// stream one entry per cycle. Full, empty, short coalesce and the unused
// opcode finish straight from idle; add back goes through the new-entry write.
// Add front and remove front shift the whole table; ordered insert and find
// scan up to the match, then shift the rest.
// Reset clears the count and the sequencer; entries are never read beyond the
// count, so the store needs no clearing. The result cannot be stalled: the
// result word stays on the result port until the next command finishes.
`timescale 1ns / 1ps
module ordered_free_block_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  oft_pkg::cmd_t    cmd,
    output logic             done,
    output oft_pkg::result_t result
);
    import oft_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_UP    = 8'b0000_1000,
        S_DN    = 8'b0001_0000,
        S_NEW   = 8'b0010_0000,
        S_COAL  = 8'b0100_0000,
        S_CFIN  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] tag_reg, tag_next;     // index of the last read issued
    logic             pend_reg, pend_next;   // read data arrives this cycle
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] w_reg, w_next;         // coalesce write pointer
    logic [2:0]       op_reg, op_next;
    entry_t           new_reg, new_next;
    entry_t           anc_reg, anc_next;     // coalesce anchor
    entry_t           out_reg, out_next;     // removed block
    result_t          res_reg, res_next;
    logic             done_reg, done_next;

    mem_req_t         mreq;
    entry_t           rd_data;

    logic [CNT_W-1:0] cnt_m1;
    logic             iss;
    logic [CNT_W-1:0] iss_idx;
    logic             go_up, go_dn, fin;
    logic [CNT_W-1:0] up_pos, dn_pos;
    logic [1:0]       fin_st;
    logic [32:0]      anc_end, sum33;

    oft_mem u_mem (
        .clk     (clk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign anc_end = {1'b0, anc_reg.addr} + {1'b0, anc_reg.size};
    assign sum33   = {1'b0, anc_reg.size} + {1'b0, rd_data.size};
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign result  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        pos_next   = pos_reg;
        w_next     = w_reg;
        op_next    = op_reg;
        new_next   = new_reg;
        anc_next   = anc_reg;
        out_next   = out_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        iss        = 1'b0;
        iss_idx    = tag_reg;
        go_up      = 1'b0;
        go_dn      = 1'b0;
        up_pos     = '0;
        dn_pos     = '0;
        fin        = 1'b0;
        fin_st     = ST_OK;
        mreq       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.opcode;
                    new_next = '{addr: cmd.block_address, size: cmd.block_size};
                    out_next = '0;
                    unique case (cmd.opcode) inside
                        OP_ADD_FRONT, OP_ADD_BACK, OP_ORD_INS:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                fin    = 1'b1;
                                fin_st = ST_FULL;
                            end
                            else if (cmd.opcode == OP_ADD_FRONT)
                            begin
                                go_up  = 1'b1;
                                up_pos = '0;
                            end
                            else if (cmd.opcode == OP_ADD_BACK || cnt_reg == '0)
                            begin
                                go_up  = 1'b1;
                                up_pos = cnt_reg;
                            end
                            else
                            begin
                                iss        = 1'b1;
                                iss_idx    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_COALESCE:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                iss        = 1'b1;
                                iss_idx    = '0;
                                w_next     = '0;
                                state_next = S_COAL;
                            end
                        end
                        OP_REM_FRONT, OP_REM_BACK, OP_FIND_REM:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin    = 1'b1;
                                fin_st = ST_EMPTY;
                            end
                            else
                            begin
                                iss        = 1'b1;
                                iss_idx    = (cmd.opcode == OP_REM_BACK) ? cnt_m1 : '0;
                                state_next = (cmd.opcode == OP_FIND_REM) ? S_SCAN
                                                                         : S_FETCH;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Stream reads ahead; a decision drops the stray read.
                if (tag_reg + CNT_W'(1) < cnt_reg)
                begin
                    iss     = 1'b1;
                    iss_idx = tag_reg + CNT_W'(1);
                end
                if (op_reg == OP_ORD_INS)
                begin
                    if (rd_data.addr > new_reg.addr)
                    begin
                        iss    = 1'b0;
                        go_up  = 1'b1;
                        up_pos = tag_reg;
                    end
                    else if (tag_reg == cnt_m1)
                    begin
                        go_up  = 1'b1;
                        up_pos = cnt_reg;
                    end
                end
                else
                begin
                    if (rd_data.addr == new_reg.addr)
                    begin
                        iss      = 1'b0;
                        out_next = rd_data;
                        go_dn    = 1'b1;
                        dn_pos   = tag_reg;
                    end
                    else if (tag_reg == cnt_m1)
                    begin
                        fin    = 1'b1;
                        fin_st = ST_MISS;
                    end
                end
            end
            S_FETCH:
            begin
                out_next = rd_data;
                go_dn    = 1'b1;
                dn_pos   = tag_reg;
            end
            S_UP:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_idx  = IDX_W'(tag_reg + CNT_W'(1));
                mreq.wr_data = rd_data;
                if (tag_reg == pos_reg)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    iss     = 1'b1;
                    iss_idx = tag_reg - CNT_W'(1);
                end
            end
            S_NEW:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_idx  = IDX_W'(pos_reg);
                mreq.wr_data = new_reg;
                cnt_next     = cnt_reg + CNT_W'(1);
                fin          = 1'b1;
            end
            S_DN:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_idx  = IDX_W'(tag_reg - CNT_W'(1));
                mreq.wr_data = rd_data;
                if (tag_reg == cnt_m1)
                begin
                    cnt_next = cnt_m1;
                    fin      = 1'b1;
                end
                else
                begin
                    iss     = 1'b1;
                    iss_idx = tag_reg + CNT_W'(1);
                end
            end
            S_COAL:
            begin
                if (tag_reg + CNT_W'(1) < cnt_reg)
                begin
                    iss     = 1'b1;
                    iss_idx = tag_reg + CNT_W'(1);
                end
                if (tag_reg == '0)
                begin
                    anc_next = rd_data;
                end
                else if (anc_end == {1'b0, rd_data.addr})
                begin
                    anc_next.size = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                end
                else
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_idx  = IDX_W'(w_reg);
                    mreq.wr_data = anc_reg;
                    w_next       = w_reg + CNT_W'(1);
                    anc_next     = rd_data;
                end
                if (tag_reg == cnt_m1)
                begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_idx  = IDX_W'(w_reg);
                mreq.wr_data = anc_reg;
                cnt_next     = w_reg + CNT_W'(1);
                fin          = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Open a shift toward the back, or go straight to the new write.
        if (go_up)
        begin
            pos_next = up_pos;
            if (up_pos == cnt_reg)
            begin
                state_next = S_NEW;
            end
            else
            begin
                iss        = 1'b1;
                iss_idx    = cnt_m1;
                state_next = S_UP;
            end
        end

        // Close the gap left by a removed entry.
        if (go_dn)
        begin
            if (dn_pos == cnt_m1)
            begin
                cnt_next = cnt_m1;
                fin      = 1'b1;
            end
            else
            begin
                iss        = 1'b1;
                iss_idx    = dn_pos + CNT_W'(1);
                state_next = S_DN;
            end
        end

        if (fin)
        begin
            done_next  = 1'b1;
            res_next   = '{status: fin_st, out_address: out_next.addr,
                           out_size: out_next.size, entry_count: COUNT_W'(cnt_next)};
            state_next = S_IDLE;
        end

        mreq.rd_en  = iss;
        mreq.rd_idx = IDX_W'(iss_idx);
        pend_next   = iss;
        if (iss)
        begin
            tag_next = iss_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        pos_reg <= pos_next;
        w_reg   <= w_next;
        op_reg  <= op_next;
        new_reg <= new_next;
        anc_reg <= anc_next;
        out_reg <= out_next;
        res_reg <= res_next;
    end

`ifndef SYNTH
    // Walks are ordered so a cycle never reads the entry it writes.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mreq.wr_en && mreq.rd_en) |-> (mreq.wr_idx != mreq.rd_idx))
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE || $past(start)))
        else $error("result without a command");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither busy nor done");

    a_data_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_UP || state_reg == S_DN ||
         state_reg == S_FETCH || state_reg == S_COAL) |-> pend_reg)
        else $error("walk step without read data");
`endif

endmodule
